// ----- rtl/core/ssrs_pkg.sv -----
// ssrs_pkg: shared types and constants of the spi shared ram slave
// no dependencies; used by ssrs_seq and spi_shared_ram_slave

package ssrs_pkg;

  // memory geometry
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MemDepth  = 1 << AddrW;
  localparam int unsigned CoreAddrW = 15;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // default line assignment
  localparam int unsigned NumLinesDef = 8;
  localparam int unsigned CoreLineDef = 5;
  localparam int unsigned SysLineDef  = 4;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgRamAccess = 2'd0,
    CfgRamRead   = 2'd1,
    CfgRamWrite  = 2'd2
  } cfg_reg_e;

  // configuration reset values
  localparam logic [DataW-1:0] RamAccessRst = 8'h01;
  localparam logic [DataW-1:0] RamReadRst   = 8'h03;
  localparam logic [DataW-1:0] RamWriteRst  = 8'h02;

  // item kinds and line levels
  localparam logic KindByte  = 1'b0;
  localparam logic KindLevel = 1'b1;
  localparam logic LevelHigh = 1'b1;

  // byte positions within a select window
  localparam logic [2:0] CntFirst   = 3'd1;
  localparam logic [2:0] CntSecond  = 3'd2;
  localparam logic [2:0] CntThird   = 3'd3;
  localparam logic [2:0] CntFourth  = 3'd4;
  localparam logic [2:0] CoreCntMax = 3'd4;
  localparam logic [2:0] SysCntMax  = 3'd5;

  // core line mode that opens the memory window
  localparam logic [DataW-1:0] CoreModeMem = 8'h01;

  // memory request of one accepted beat
  typedef struct packed {
    logic             ret;    // result is the byte read
    logic             wr;     // write wdata at addr
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

endpackage

// ----- rtl/core/ssrs_seq.sv -----
// ssrs_seq: chip-select tracking, per-line byte sequencing and config registers
// depends on ssrs_pkg; issues one memory request per accepted beat

module ssrs_seq import ssrs_pkg::*; #(
  parameter int unsigned NUM_LINES = NumLinesDef,
  parameter int unsigned CORE_LINE = CoreLineDef,
  parameter int unsigned SYS_LINE  = SysLineDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  logic                kind_i,
  input  logic [2:0]          line_i,
  input  logic                level_i,
  input  logic [DataW-1:0]    data_in_i,
  output mem_req_t            req_o
);

  localparam int unsigned LineIdxW = $clog2(NUM_LINES);

  logic [DataW-1:0]     ram_access_q, ram_read_q, ram_write_q;
  logic [NUM_LINES-1:0] levels_q, levels_d;
  logic [2:0]           core_cnt_q, core_cnt_d, core_cnt_n;
  logic [DataW-1:0]     core_mode_q, core_mode_d;
  logic [CoreAddrW-1:0] core_addr_q, core_addr_d;
  logic                 core_wflag_q, core_wflag_d;
  logic [2:0]           sys_cnt_q, sys_cnt_d, sys_cnt_n;
  logic [DataW-1:0]     sys_op_q, sys_op_d;
  logic [DataW-1:0]     sys_ram_op_q, sys_ram_op_d;
  logic [AddrW-1:0]     sys_addr_q, sys_addr_d;
  logic                 core_hit, core_blk, sys_hit, sys_blk, core_sel, sys_sel;
  logic                 line_ok;
  logic [LineIdxW-1:0]  line_idx;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_access_q <= RamAccessRst;
      ram_read_q   <= RamReadRst;
      ram_write_q  <= RamWriteRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgRamAccess: ram_access_q <= cfg_wdata_i;
        CfgRamRead:   ram_read_q   <= cfg_wdata_i;
        CfgRamWrite:  ram_write_q  <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // lowest low line decides who owns a byte
  always_comb begin
    core_hit = 1'b0;
    core_blk = 1'b0;
    sys_hit  = 1'b0;
    sys_blk  = 1'b0;
    for (int unsigned i = 0; i < NUM_LINES; i++) begin
      if (!levels_q[i]) begin
        if (i < CORE_LINE)  core_blk = 1'b1;
        if (i == CORE_LINE) core_hit = 1'b1;
        if (i < SYS_LINE)   sys_blk  = 1'b1;
        if (i == SYS_LINE)  sys_hit  = 1'b1;
      end
    end
  end

  assign core_sel = core_hit && !core_blk;
  assign sys_sel  = sys_hit && !sys_blk && (CORE_LINE != SYS_LINE);

  assign line_ok  = 32'(line_i) < NUM_LINES;
  assign line_idx = LineIdxW'(line_i);

  // saturating byte counters
  assign core_cnt_n = (core_cnt_q < CoreCntMax) ? core_cnt_q + 3'd1 : core_cnt_q;
  assign sys_cnt_n  = (sys_cnt_q < SysCntMax) ? sys_cnt_q + 3'd1 : sys_cnt_q;

  // sequence update and memory request
  always_comb begin
    levels_d     = levels_q;
    core_cnt_d   = core_cnt_q;
    core_mode_d  = core_mode_q;
    core_addr_d  = core_addr_q;
    core_wflag_d = core_wflag_q;
    sys_cnt_d    = sys_cnt_q;
    sys_op_d     = sys_op_q;
    sys_ram_op_d = sys_ram_op_q;
    sys_addr_d   = sys_addr_q;
    req_o        = '0;

    if (accept_i && (kind_i == KindLevel)) begin
      if (line_ok) begin
        if (level_i == LevelHigh) begin
          if (32'(line_i) == CORE_LINE) begin
            core_cnt_d  = '0;
            core_mode_d = '0;
          end
          if (32'(line_i) == SYS_LINE) sys_cnt_d = '0;
        end
        levels_d[line_idx] = level_i;
      end
    end else if (accept_i && core_sel) begin
      // core line: mode, flag with high address, low address, data
      core_cnt_d = core_cnt_n;
      if (core_cnt_n == CntFirst) begin
        core_mode_d = data_in_i;
      end else if (core_mode_q == CoreModeMem) begin
        if (core_cnt_n == CntSecond) begin
          core_wflag_d = data_in_i[DataW-1];
          core_addr_d  = {8'h00, data_in_i[DataW-2:0]};
        end else if (core_cnt_n == CntThird) begin
          core_addr_d = {core_addr_q[CoreAddrW-DataW-1:0], data_in_i};
        end else begin
          req_o.ret   = 1'b1;
          req_o.wr    = core_wflag_q;
          req_o.addr  = {1'b1, core_addr_q};
          req_o.wdata = data_in_i;
          core_addr_d = core_addr_q + 15'd1;
        end
      end
    end else if (accept_i && sys_sel) begin
      // system line: opcode, sub-opcode, address high, address low, data
      sys_cnt_d = sys_cnt_n;
      if (sys_cnt_n == CntFirst) begin
        sys_op_d = data_in_i;
      end else if (sys_op_q == ram_access_q) begin
        if (sys_cnt_n == CntSecond) begin
          sys_ram_op_d = data_in_i;
        end else if (sys_cnt_n == CntThird) begin
          sys_addr_d = {8'h00, data_in_i};
        end else if (sys_cnt_n == CntFourth) begin
          sys_addr_d = {sys_addr_q[DataW-1:0], data_in_i};
        end else if (sys_ram_op_q == ram_read_q) begin
          req_o.ret  = 1'b1;
          req_o.addr = sys_addr_q;
          sys_addr_d = sys_addr_q + 16'd1;
        end else if (sys_ram_op_q == ram_write_q) begin
          req_o.wr    = 1'b1;
          req_o.addr  = sys_addr_q;
          req_o.wdata = data_in_i;
          sys_addr_d  = sys_addr_q + 16'd1;
        end
      end
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q     <= '1;
      core_cnt_q   <= '0;
      core_mode_q  <= '0;
      core_addr_q  <= '0;
      core_wflag_q <= 1'b0;
      sys_cnt_q    <= '0;
      sys_op_q     <= '0;
      sys_ram_op_q <= '0;
      sys_addr_q   <= '0;
    end else begin
      levels_q     <= levels_d;
      core_cnt_q   <= core_cnt_d;
      core_mode_q  <= core_mode_d;
      core_addr_q  <= core_addr_d;
      core_wflag_q <= core_wflag_d;
      sys_cnt_q    <= sys_cnt_d;
      sys_op_q     <= sys_op_d;
      sys_ram_op_q <= sys_ram_op_d;
      sys_addr_q   <= sys_addr_d;
    end
  end

endmodule

// ----- rtl/core/spi_shared_ram_slave.sv -----
// spi_shared_ram_slave: top level with the shared 64 KiB memory and result pipeline
// depends on ssrs_pkg and ssrs_seq
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------
//   in       | input     | in_valid_i / in_stall_o | kind_i, line_i, level_i, data_in_i
//   out      | output    | out_valid_o / out_stall_i | data_out_o
//   cfg      | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// one beat a cycle while in_stall_o is low; each taken beat's result passes the memory
// read stage, then the output register; the single memory port does
// one read and one write per cycle, read before write
// after reset a clearing pass zeroes the memory, no beats taken
// with the output stalled one more beat is taken and held in the read stage

module spi_shared_ram_slave import ssrs_pkg::*; #(
  parameter int unsigned NUM_LINES = NumLinesDef,
  parameter int unsigned CORE_LINE = CoreLineDef,
  parameter int unsigned SYS_LINE  = SysLineDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [2:0]          line_i,
  input  logic                level_i,
  input  logic [DataW-1:0]    data_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DataW-1:0]    data_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  mem_req_t         req;
  logic             in_accept, out_accept;
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] mem_q [MemDepth];
  logic [DataW-1:0] rd_q;
  logic             s1_valid_q, s1_valid_d, s1_ret_q, s1_move;
  logic             s2_valid_q, s2_valid_d;
  logic [DataW-1:0] s2_data_q;

  // sequencing and configuration
  ssrs_seq #(
    .NUM_LINES(NUM_LINES),
    .CORE_LINE(CORE_LINE),
    .SYS_LINE (SYS_LINE)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (in_accept),
    .kind_i     (kind_i),
    .line_i     (line_i),
    .level_i    (level_i),
    .data_in_i  (data_in_i),
    .req_o      (req)
  );

  // handshakes
  assign out_accept = s2_valid_q && !out_stall_i;
  assign s1_move    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_move);
  assign in_accept  = in_valid_i && !in_stall_o;

  // clearing pass after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 16'd1;
      if (clr_addr_q == '1) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // memory port
  assign mem_we    = clr_busy_q || req.wr;
  assign mem_addr  = clr_busy_q ? clr_addr_q : req.addr;
  assign mem_wdata = clr_busy_q ? '0 : req.wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (in_accept) rd_q <= mem_q[mem_addr];
  end

  // read stage and output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept)    s1_valid_d = 1'b1;
    else if (s1_move) s1_valid_d = 1'b0;
    s2_valid_d = s2_valid_q;
    if (s1_move)         s2_valid_d = 1'b1;
    else if (out_accept) s2_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_ret_q <= req.ret;
    if (s1_move) s2_data_q <= s1_ret_q ? rd_q : '0;
  end

  assign out_valid_o = s2_valid_q;
  assign data_out_o  = s2_data_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(rd_q)))
    else $error("read stage lost its data while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted beat did not enter the read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req.wr)
    else $error("sequence write during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_addr_q) == '1))
    else $error("clearing pass ended early");

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for the spi shared ram slave, random and directed beats
// depends on ssrs_pkg and spi_shared_ram_slave; holds its own model of lines and memory

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssrs_pkg::*;

  localparam int unsigned Period     = 20;
  localparam int unsigned CycleLimit = 400_000;
  localparam logic        LevelLow   = ~LevelHigh;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct {
    logic             kind;
    logic [2:0]       ln;
    logic             lvl;
    logic [DataW-1:0] data;
    int unsigned      gap;
  } beat_t;

  // clock, reset, block inputs and block outputs
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                kind_i      = KindByte;
  logic [2:0]          line_i      = '0;
  logic                level_i     = LevelHigh;
  logic [DataW-1:0]    data_in_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgRamAccess;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [DataW-1:0]    data_out_o;

  // bench bookkeeping
  beat_t            beat_queue[$];
  logic [DataW-1:0] reply_queue[$];
  int unsigned      beats_issued = 0;
  int unsigned      beats_taken  = 0;
  int unsigned      err_count    = 0;
  int unsigned      cycle_count  = 0;
  int unsigned      tx_wait      = 0;
  int unsigned      rx_wait      = 0;
  bit               tx_calm      = 1'b0;
  bit               rx_calm      = 1'b0;
  logic             in_took      = 1'b0;
  logic             out_took     = 1'b0;
  logic [NumLinesDef-1:0] gen_lvl = '1;

  // model state
  logic [DataW-1:0]       acc_opcode = RamAccessRst;
  logic [DataW-1:0]       rd_code    = RamReadRst;
  logic [DataW-1:0]       wr_code    = RamWriteRst;
  logic [NumLinesDef-1:0] sel_level  = '1;
  logic [2:0]             core_cnt   = '0;
  logic [DataW-1:0]       core_mode  = '0;
  logic [CoreAddrW-1:0]   core_addr  = '0;
  logic                   core_wr    = 1'b0;
  logic [2:0]             sys_cnt    = '0;
  logic [DataW-1:0]       sys_op     = '0;
  logic [DataW-1:0]       sys_ram_op = '0;
  logic [AddrW-1:0]       sys_addr   = '0;
  logic [DataW-1:0]       shadow_mem [MemDepth];

  spi_shared_ram_slave dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .line_i      (line_i),
    .level_i     (level_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(Period / 2) clk_i = ~clk_i;

  // next byte the slave returns for one accepted beat, updating the model state
  function automatic logic [DataW-1:0] serve_beat(input logic kind, input logic [2:0] ln,
                                                  input logic lvl, input logic [DataW-1:0] d);
    logic [DataW-1:0] res;
    int               i;
    res = '0;
    if (kind == KindLevel) begin
      if (lvl == LevelHigh) begin
        if (32'(ln) == CoreLineDef) begin
          core_cnt  = '0;
          core_mode = '0;
        end
        if (32'(ln) == SysLineDef) sys_cnt = '0;
      end
      sel_level[ln] = lvl;
    end else begin
      for (i = 0; i < NumLinesDef; i++) begin
        if (sel_level[i] == LevelLow) begin
          if (i == CoreLineDef) begin
            // core line: mode byte, flag and high address, low address, then data
            if (core_cnt < CoreCntMax) core_cnt++;
            if (core_cnt == CntFirst) begin
              core_mode = d;
            end else if (core_mode == CoreModeMem) begin
              if (core_cnt == CntSecond) begin
                core_wr   = d[7];
                core_addr = {8'h00, d[6:0]};
              end else if (core_cnt == CntThird) begin
                core_addr = {core_addr[6:0], d};
              end else begin
                res = shadow_mem[{1'b1, core_addr}];
                if (core_wr) shadow_mem[{1'b1, core_addr}] = d;
                core_addr = core_addr + 15'd1;
              end
            end
          end else if (i == SysLineDef) begin
            // system line: opcode, sub-opcode, address high and low, then data
            if (sys_cnt < SysCntMax) sys_cnt++;
            if (sys_cnt == CntFirst) begin
              sys_op = d;
            end else if (sys_op == acc_opcode) begin
              if (sys_cnt == CntSecond) begin
                sys_ram_op = d;
              end else if (sys_cnt == CntThird) begin
                sys_addr = {8'h00, d};
              end else if (sys_cnt == CntFourth) begin
                sys_addr = {sys_addr[7:0], d};
              end else if (sys_ram_op == rd_code) begin
                res      = shadow_mem[sys_addr];
                sys_addr = sys_addr + 16'd1;
              end else if (sys_ram_op == wr_code) begin
                shadow_mem[sys_addr] = d;
                sys_addr             = sys_addr + 16'd1;
              end
            end
          end
          break;
        end
      end
    end
    return res;
  endfunction

  // queue one beat with its trailing gap
  task automatic push_beat(input logic kind, input logic [2:0] ln, input logic lvl,
                           input logic [DataW-1:0] data);
    beat_t b;
    b.kind = kind;
    b.ln   = ln;
    b.lvl  = lvl;
    b.data = data;
    b.gap  = tx_calm ? 0 : $urandom_range(0, 16);
    if (kind == KindLevel) gen_lvl[ln] = lvl;
    beat_queue.push_back(b);
    beats_issued++;
  endtask

  // one select window on the core or system line, mostly well formed
  task automatic gen_frame(input bit to_sys);
    logic [2:0]       tgt;
    logic [DataW-1:0] hdr [4];
    logic [DataW-1:0] lo;
    int unsigned      hlen;
    tgt = to_sys ? 3'(SysLineDef) : 3'(CoreLineDef);
    case ($urandom_range(0, 3))
      0:       lo = 8'($urandom);
      1:       lo = 8'hFF;
      default: lo = 8'($urandom_range(0, 31));
    endcase
    // any lower line still selected would steal the bytes
    for (int i = 0; i < int'(tgt); i++)
      if (gen_lvl[i] == LevelLow) push_beat(KindLevel, 3'(i), LevelHigh, 8'($urandom));
    push_beat(KindLevel, tgt, LevelHigh, 8'($urandom));
    push_beat(KindLevel, tgt, LevelLow, 8'($urandom));
    if (to_sys) begin
      hdr[0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : acc_opcode;
      case ($urandom_range(0, 7))
        0, 1, 2: hdr[1] = rd_code;
        3, 4, 5: hdr[1] = wr_code;
        default: hdr[1] = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       hdr[2] = 8'($urandom);
        1:       hdr[2] = 8'h80;
        2:       hdr[2] = 8'hFF;
        default: hdr[2] = 8'h00;
      endcase
      hdr[3] = lo;
      hlen   = 4;
    end else begin
      hdr[0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CoreModeMem;
      case ($urandom_range(0, 3))
        0:       hdr[1][6:0] = 7'($urandom);
        1:       hdr[1][6:0] = 7'h7F;
        default: hdr[1][6:0] = 7'h00;
      endcase
      hdr[1][7] = 1'($urandom);
      hdr[2]    = lo;
      hlen      = 3;
    end
    // now and then a header cut short
    if ($urandom_range(0, 7) == 0) hlen = $urandom_range(0, hlen - 1);
    for (int i = 0; i < int'(hlen); i++)
      push_beat(KindByte, 3'($urandom), 1'($urandom), hdr[i]);
    repeat ($urandom_range(0, 12)) push_beat(KindByte, 3'($urandom), 1'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) != 0) push_beat(KindLevel, tgt, LevelHigh, 8'($urandom));
  endtask

  // random stimulus: frames on both lines with stray beats mixed in
  task automatic fill_random(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    goal = beats_issued + n;
    while (beats_issued < goal) begin
      pick    = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (pick < 8) begin
        gen_frame(pick >= 4);
      end else begin
        repeat ($urandom_range(1, 6))
          push_beat(1'($urandom), 3'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  // wait until every beat is taken and every reply has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (beats_taken != beats_issued || reply_queue.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // input driver: new beat only once the previous one is taken
  always @(negedge clk_i) begin : driver
    beat_t nxt;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (tx_wait > 0) begin
        in_valid_i <= 1'b0;
        tx_wait--;
      end else if (beat_queue.size() != 0) begin
        nxt = beat_queue.pop_front();
        kind_i     <= nxt.kind;
        line_i     <= nxt.ln;
        level_i    <= nxt.lvl;
        data_in_i  <= nxt.data;
        in_valid_i <= 1'b1;
        tx_wait    = nxt.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure, drawn after every reply beat
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (out_took) rx_wait = rx_calm ? 0 : $urandom_range(0, 16);
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: config tracking, reply checks and prediction of taken beats
  always @(posedge clk_i) begin : monitor
    logic [DataW-1:0] want;
    in_took  <= rst_ni && in_valid_i && !in_stall_o;
    out_took <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgRamAccess: acc_opcode = cfg_wdata_i;
          CfgRamRead:   rd_code    = cfg_wdata_i;
          CfgRamWrite:  wr_code    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (reply_queue.size() == 0) begin
          $error("data_out: expected none, actual %02h", data_out_o);
          err_count++;
        end else begin
          want = reply_queue.pop_front();
          if (data_out_o !== want) begin
            $error("data_out: expected %02h, actual %02h", want, data_out_o);
            err_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        reply_queue.push_back(serve_beat(kind_i, line_i, level_i, data_in_i));
        beats_taken++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: nothing selected, a foreign line, core edges, system edges
    push_beat(KindByte, 3'd0, LevelHigh, 8'hFF);
    push_beat(KindLevel, 3'd0, LevelLow, 8'h00);
    push_beat(KindByte, 3'd0, LevelLow, 8'h5A);
    push_beat(KindLevel, 3'd0, LevelHigh, 8'hFF);
    // core write at the top of the window, then address wrap
    push_beat(KindLevel, 3'(CoreLineDef), LevelLow, 8'h00);
    push_beat(KindByte, 3'd7, LevelHigh, CoreModeMem);
    push_beat(KindByte, 3'd7, LevelHigh, 8'hFF);
    push_beat(KindByte, 3'd7, LevelHigh, 8'hFF);
    push_beat(KindByte, 3'd7, LevelHigh, 8'hAA);
    push_beat(KindByte, 3'd7, LevelHigh, 8'h55);
    push_beat(KindLevel, 3'(CoreLineDef), LevelHigh, 8'h00);
    // system read across the top of memory
    push_beat(KindLevel, 3'(SysLineDef), LevelLow, 8'hFF);
    push_beat(KindByte, 3'd0, LevelLow, RamAccessRst);
    push_beat(KindByte, 3'd0, LevelLow, RamReadRst);
    push_beat(KindByte, 3'd0, LevelLow, 8'hFF);
    push_beat(KindByte, 3'd0, LevelLow, 8'hFF);
    push_beat(KindByte, 3'd0, LevelLow, 8'h00);
    push_beat(KindByte, 3'd0, LevelLow, 8'h00);
    // both lines low: the lower one wins, counter saturated
    push_beat(KindLevel, 3'(CoreLineDef), LevelLow, 8'h00);
    push_beat(KindByte, 3'd0, LevelLow, 8'h33);
    // core alone with a mode other than memory
    push_beat(KindLevel, 3'(SysLineDef), LevelHigh, 8'h00);
    push_beat(KindByte, 3'd0, LevelLow, 8'h07);
    push_beat(KindByte, 3'd0, LevelLow, 8'h12);
    // raising a line twice
    push_beat(KindLevel, 3'(CoreLineDef), LevelHigh, 8'h00);
    push_beat(KindLevel, 3'(CoreLineDef), LevelHigh, 8'h00);
    fill_random(175);
    wait_idle();

    // extreme codes
    write_reg(CfgRamAccess, 8'hFF);
    write_reg(CfgRamRead, 8'h00);
    write_reg(CfgRamWrite, 8'hFF);
    fill_random(175);
    wait_idle();

    // read and write codes equal, with a full drain half way
    write_reg(CfgRamAccess, 8'h00);
    write_reg(CfgRamRead, 8'h5A);
    write_reg(CfgRamWrite, 8'h5A);
    fill_random(90);
    wait_idle();
    fill_random(90);
    wait_idle();

    // unused index, then random codes
    write_reg(CfgSpare, 8'($urandom));
    write_reg(CfgRamAccess, 8'($urandom));
    write_reg(CfgRamRead, 8'($urandom));
    write_reg(CfgRamWrite, 8'($urandom));
    fill_random(175);
    wait_idle();

    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
